### rtl/core/json_array_object_splitter_top_macros.svh
// Assertion macros used by the checker file.
`ifndef JSON_ARRAY_OBJECT_SPLITTER_TOP_MACROS_SVH
`define JSON_ARRAY_OBJECT_SPLITTER_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define JAOS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define JAOS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/jaos_pkg.sv
`timescale 1ns / 1ps

package jaos_pkg;

   localparam int MAX_DEPTH_DEF  = 255;
   localparam int COUNT_BITS_DEF = 16;

   localparam logic [7:0] CH_LBRACKET = 8'h5B;  // [
   localparam logic [7:0] CH_RBRACKET = 8'h5D;  // ]
   localparam logic [7:0] CH_LBRACE   = 8'h7B;  // {
   localparam logic [7:0] CH_RBRACE   = 8'h7D;  // }
   localparam logic [7:0] CH_COMMA    = 8'h2C;  // ,

   typedef enum logic [5:0] {
      PH_OPEN   = 6'b000001,
      PH_FIRST  = 6'b000010,
      PH_OBJECT = 6'b000100,
      PH_SEP    = 6'b001000,
      PH_NEXT   = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      E_NONE       = 3'd0,
      E_NO_BRACKET = 3'd1,
      E_NO_BRACE   = 3'd2,
      E_EARLY_END  = 3'd3,
      E_TRAILING   = 3'd4,
      E_SEPARATOR  = 3'd5,
      E_TOO_DEEP   = 3'd6
   } err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
      logic       restart;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_valid;
      logic        object_last;
      logic        array_done;
      logic        more_follow;
      logic [15:0] object_count;
      err_type     error_code;
   } rsp_item_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) || (b == 8'h20);
   endfunction

endpackage

### rtl/core/jaos_stage.sv
`timescale 1ns / 1ps

// One register stage with valid/stall flow control.
module jaos_stage #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_stall,
   output logic [W-1:0] out_data
);

   logic         valid_ff, valid_in;
   logic [W-1:0] data_ff, data_in;

   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (!in_stall) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

### rtl/core/jaos_parser.sv
`timescale 1ns / 1ps

// Parse state and the one-step update for a single beat.
module jaos_parser #(
   parameter int MAX_DEPTH  = jaos_pkg::MAX_DEPTH_DEF,
   parameter int COUNT_BITS = jaos_pkg::COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  jaos_pkg::req_item_type item,
   output jaos_pkg::rsp_item_type result
);

   localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);
   localparam logic [DEPTH_BITS-1:0] DEPTH_TOP = DEPTH_BITS'(MAX_DEPTH);
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

   jaos_pkg::phase_type    phase_ff, phase_in;
   jaos_pkg::err_type      err_ff, err_in;
   logic [DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   byte_out, last_out;
   logic [7:0]             b;

   assign b = item.data_byte;

   always_comb begin
      phase_in = phase_ff;
      err_in   = err_ff;
      depth_in = depth_ff;
      count_in = count_ff;
      byte_out = 1'b0;
      last_out = 1'b0;
      if (item.restart) begin
         phase_in = jaos_pkg::PH_OPEN;
         err_in   = jaos_pkg::E_NONE;
         depth_in = '0;
         count_in = '0;
      end else if (err_ff == jaos_pkg::E_NONE) begin
         if (item.end_of_text) begin
            unique case (phase_ff)
               jaos_pkg::PH_OPEN:   err_in = jaos_pkg::E_NO_BRACKET;
               jaos_pkg::PH_FIRST,
               jaos_pkg::PH_NEXT:   err_in = jaos_pkg::E_NO_BRACE;
               jaos_pkg::PH_OBJECT,
               jaos_pkg::PH_SEP:    err_in = jaos_pkg::E_EARLY_END;
               jaos_pkg::PH_DONE:   err_in = jaos_pkg::E_NONE;
               default:             err_in = err_ff;
            endcase
         end else if (phase_ff == jaos_pkg::PH_OBJECT) begin
            if (b == jaos_pkg::CH_LBRACE) begin
               if (depth_ff == DEPTH_TOP) begin
                  err_in = jaos_pkg::E_TOO_DEEP;
               end else begin
                  depth_in = depth_ff + 1'b1;
                  byte_out = 1'b1;
               end
            end else begin
               byte_out = 1'b1;
               if (b == jaos_pkg::CH_RBRACE) begin
                  depth_in = depth_ff - 1'b1;
                  if (depth_ff == DEPTH_BITS'(1)) begin
                     last_out = 1'b1;
                     phase_in = jaos_pkg::PH_SEP;
                     if (count_ff != COUNT_TOP) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
            end
         end else if (!jaos_pkg::is_space(b)) begin
            unique case (phase_ff)
               jaos_pkg::PH_OPEN: begin
                  if (b == jaos_pkg::CH_LBRACKET) phase_in = jaos_pkg::PH_FIRST;
                  else err_in = jaos_pkg::E_NO_BRACKET;
               end
               jaos_pkg::PH_FIRST,
               jaos_pkg::PH_NEXT: begin
                  priority if (b == jaos_pkg::CH_LBRACE) begin
                     phase_in = jaos_pkg::PH_OBJECT;
                     depth_in = DEPTH_BITS'(1);
                     byte_out = 1'b1;
                  end else if (b == jaos_pkg::CH_RBRACKET
                               && phase_ff == jaos_pkg::PH_FIRST) begin
                     phase_in = jaos_pkg::PH_DONE;
                  end else begin
                     err_in = jaos_pkg::E_NO_BRACE;
                  end
               end
               jaos_pkg::PH_SEP: begin
                  priority if (b == jaos_pkg::CH_COMMA) phase_in = jaos_pkg::PH_NEXT;
                  else if (b == jaos_pkg::CH_RBRACKET) phase_in = jaos_pkg::PH_DONE;
                  else err_in = jaos_pkg::E_SEPARATOR;
               end
               jaos_pkg::PH_DONE:   err_in = jaos_pkg::E_TRAILING;
               // object phase handled above
               default:             err_in = err_ff;
            endcase
         end
      end
   end

   always_comb begin
      result.out_byte     = byte_out ? b : 8'h00;
      result.out_valid    = byte_out;
      result.object_last  = last_out;
      result.array_done   = (phase_in == jaos_pkg::PH_DONE);
      result.more_follow  = (err_in == jaos_pkg::E_NONE) && (phase_in == jaos_pkg::PH_NEXT);
      result.object_count = 16'(count_in);
      result.error_code   = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jaos_pkg::PH_OPEN;
         err_ff   <= jaos_pkg::E_NONE;
         depth_ff <= '0;
         count_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         err_ff   <= err_in;
         depth_ff <= depth_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/json_array_object_splitter_top.sv
`timescale 1ns / 1ps

// Splits a JSON text holding one top-level array of objects into the bytes of
// each object, one text byte per beat in, one result beat out per byte. Bytes
// of an object come out unchanged with out_valid set, its closing brace also
// flagged by object_last; everything outside objects (brackets, commas,
// whitespace) gives a beat with out_valid clear. Status (array_done,
// more_follow, object_count, error_code) rides on every result beat. The first
// error is held until a beat with restart set. A new byte is taken every
// cycle while req_stall is low; each byte passes through the input register,
// then the parse step, whose state update happens in the same cycle as the
// beat moves into the result register.
// req_stall only rises when both registers hold a beat and rsp_stall is high.
module json_array_object_splitter_top #(
   parameter int MAX_DEPTH  = jaos_pkg::MAX_DEPTH_DEF,   // brace nesting bound
   parameter int COUNT_BITS = jaos_pkg::COUNT_BITS_DEF   // object counter width
) (
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_text,
   input  logic        req_restart,
   // result beats out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_valid,
   output logic        rsp_object_last,
   output logic        rsp_array_done,
   output logic        rsp_more_follow,
   output logic [15:0] rsp_object_count,
   output logic [2:0]  rsp_error_code
);

   localparam int REQ_W = $bits(jaos_pkg::req_item_type);
   localparam int RSP_W = $bits(jaos_pkg::rsp_item_type);

   jaos_pkg::req_item_type req_item, held_item;
   jaos_pkg::rsp_item_type step_result, rsp_item;
   logic                   held_valid;
   logic                   out_stage_stall;
   logic                   step_advance;

   // pack the incoming beat
   always_comb begin
      req_item.data_byte   = req_data_byte;
      req_item.end_of_text = req_end_of_text;
      req_item.restart     = req_restart;
   end

   // input register
   jaos_stage #(
      .W(REQ_W)
   ) u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_item),
      .out_valid (held_valid),
      .out_stall (out_stage_stall),
      .out_data  (held_item)
   );

   // parse state moves only when the held beat is handed on
   assign step_advance = held_valid && !out_stage_stall;

   jaos_parser #(
      .MAX_DEPTH  (MAX_DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (step_advance),
      .item    (held_item),
      .result  (step_result)
   );

   // result register
   jaos_stage #(
      .W(RSP_W)
   ) u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (held_valid),
      .in_stall  (out_stage_stall),
      .in_data   (step_result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_item)
   );

   // unpack the result beat
   assign rsp_out_byte     = rsp_item.out_byte;
   assign rsp_out_valid    = rsp_item.out_valid;
   assign rsp_object_last  = rsp_item.object_last;
   assign rsp_array_done   = rsp_item.array_done;
   assign rsp_more_follow  = rsp_item.more_follow;
   assign rsp_object_count = rsp_item.object_count;
   assign rsp_error_code   = rsp_item.error_code;

endmodule

### rtl/core/jaos_checker.sv
`timescale 1ns / 1ps
`include "json_array_object_splitter_top_macros.svh"

// Port-level checks on the splitter's result channel.
module jaos_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_out_valid,
   input logic        rsp_object_last,
   input logic        rsp_array_done,
   input logic        rsp_more_follow,
   input logic [15:0] rsp_object_count,
   input logic [2:0]  rsp_error_code
);

   `JAOS_ASSERT(a_last_is_brace,
      rsp_valid && rsp_object_last |-> rsp_out_valid && rsp_out_byte == jaos_pkg::CH_RBRACE,
      "object_last without a closing brace")
   `JAOS_ASSERT(a_err_no_bytes,
      rsp_valid && rsp_error_code != jaos_pkg::E_NONE |-> !rsp_out_valid && !rsp_more_follow,
      "object byte after an error")
   `JAOS_ASSERT(a_more_not_done,
      rsp_valid && rsp_more_follow |-> !rsp_array_done && !rsp_out_valid,
      "more_follow with array closed or byte out")
   `JAOS_ASSERT(a_rsp_hold,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_object_count) && $stable(rsp_error_code),
      "stalled result beat changed")
   `JAOS_ASSERT_ALWAYS(a_no_valid_in_reset,
      $past(reset) |-> !rsp_valid,
      "result beat right after reset")

endmodule

bind json_array_object_splitter_top jaos_checker u_jaos_checker (.*);
